// File: design/sibs_pkg.sv
// Shared types, constants and helpers for the sorted index search core.
package sibs_pkg;

    localparam int DEPTH     = 256;
    localparam int VALUE_W   = 32;
    localparam int POS_OUT_W = 9;
    localparam int LEVELS    = $clog2(DEPTH);
    localparam int NP        = 1 << LEVELS;
    localparam int NODES     = NP - 1;
    localparam int PW        = LEVELS;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int WAIT_W    = $clog2(LEVELS + 2);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [CNT_W-1:0]     COUNT_FULL = CNT_W'(DEPTH);
    localparam logic [WAIT_W-1:0]    WAIT_DONE  = WAIT_W'(LEVELS);
    localparam logic [POS_OUT_W-1:0] POS_NONE   = '1;

    typedef struct packed {
        logic                      clear;
        logic                      load;
        logic signed [VALUE_W-1:0] key;
        logic [PW-1:0]             new_pos;
    } t_cell_ctl;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [PW-1:0]             pos;
        logic                      gt;
        logic                      eq;
    } t_link;

    typedef struct packed {
        logic          hit;
        logic [PW-1:0] pos;
    } t_leaf;

    function automatic logic [POS_OUT_W-1:0] to_position(input logic [PW-1:0] p);
        logic [PW+POS_OUT_W-1:0] ext;
        ext = (PW + POS_OUT_W)'(p);
        return ext[POS_OUT_W-1:0];
    endfunction

endpackage

// File: design/sibs_if.sv
// Valid/ready channel interfaces for commands in and search results out.
interface sibs_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            command;
    logic signed [sibs_pkg::VALUE_W-1:0]   value;

    modport source (output valid, command, value, input ready);
    modport sink   (input valid, command, value, output ready);
endinterface

interface sibs_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  found;
    logic signed [sibs_pkg::POS_OUT_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

// File: design/sibs_cell.sv
// One table cell: holds a value and its load position, shifts on insert.
module sibs_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sibs_pkg::t_cell_ctl i_ctl,
    input  sibs_pkg::t_link     i_prev,
    output sibs_pkg::t_link     o_link,
    output sibs_pkg::t_leaf     o_leaf
);

    logic                               r_valid;
    logic signed [sibs_pkg::VALUE_W-1:0] r_value;
    logic [sibs_pkg::PW-1:0]            r_pos;
    logic                               r_hit;
    logic [sibs_pkg::PW-1:0]            r_hpos;
    logic                               w_gt;
    logic                               w_eq;
    logic                               w_first;

    // An empty cell counts as greater than any key, so empties sit after the data.
    always_comb begin
        w_gt    = !r_valid || ($signed(r_value) > $signed(i_ctl.key));
        w_eq    = r_valid && (r_value == i_ctl.key);
        w_first = w_eq && !i_prev.eq;
    end

    assign o_link = '{valid: r_valid, value: r_value, pos: r_pos, gt: w_gt, eq: w_eq};
    assign o_leaf = '{hit: r_hit, pos: r_hpos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load && w_gt) begin
            r_valid <= i_prev.gt ? i_prev.valid : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        // shift from the left neighbor, or take the new word at the insert point
        if (i_ctl.load && w_gt) begin
            if (i_prev.gt) begin
                r_value <= i_prev.value;
                r_pos   <= i_prev.pos;
            end else begin
                r_value <= i_ctl.key;
                r_pos   <= i_ctl.new_pos;
            end
        end
        r_hit  <= w_first;
        r_hpos <= w_first ? r_pos : '0;
    end

endmodule

// File: design/sibs_or_tree.sv
// Registered OR tree that folds the one-hot first-match leaves into one result.
module sibs_or_tree (
    input  logic            i_clk,
    input  sibs_pkg::t_leaf i_leaf [sibs_pkg::DEPTH],
    output sibs_pkg::t_leaf o_root
);

    sibs_pkg::t_leaf r_node [sibs_pkg::NODES];

    for (genvar k = 0; k < sibs_pkg::NODES; k++) begin : g_node
        sibs_pkg::t_leaf w_a;
        sibs_pkg::t_leaf w_b;

        if (2 * k + 1 < sibs_pkg::NODES) begin : g_a_node
            assign w_a = r_node[2 * k + 1];
        end else if (2 * k + 1 - sibs_pkg::NODES < sibs_pkg::DEPTH) begin : g_a_leaf
            assign w_a = i_leaf[2 * k + 1 - sibs_pkg::NODES];
        end else begin : g_a_pad
            assign w_a = '0;
        end

        if (2 * k + 2 < sibs_pkg::NODES) begin : g_b_node
            assign w_b = r_node[2 * k + 2];
        end else if (2 * k + 2 - sibs_pkg::NODES < sibs_pkg::DEPTH) begin : g_b_leaf
            assign w_b = i_leaf[2 * k + 2 - sibs_pkg::NODES];
        end else begin : g_b_pad
            assign w_b = '0;
        end

        always_ff @(posedge i_clk) begin
            r_node[k].hit <= w_a.hit | w_b.hit;
            r_node[k].pos <= w_a.pos | w_b.pos;
        end
    end

    assign o_root = r_node[0];

endmodule

// File: design/sorted_index_binary_search_core.sv
// Top level: sorted value table built from a chain of cells, with a search tree.
// The table holds up to DEPTH signed 32-bit values in ascending order, each
// tagged with its load position; equal values keep load order. Clear, load and
// the unused command code are taken at one per cycle while no query is busy;
// a load into a full table is dropped. A query holds the input while the
// per-cell match is registered, then each level of the registered OR tree,
// then the output register. It returns the smallest load position among
// the matching entries, or not found with position all ones. The result sits
// in an output register, and the next command is accepted while it waits; a
// query that would finish before the result is taken stays busy until it is.
module sorted_index_binary_search_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sibs_in_if.sink          i_in,
    sibs_out_if.source       o_out
);

    logic                                r_busy;
    logic [sibs_pkg::WAIT_W-1:0]         r_wait;
    logic [sibs_pkg::CNT_W-1:0]          r_count;
    logic signed [sibs_pkg::VALUE_W-1:0] r_key;
    logic                                r_out_valid;
    logic                                r_found;
    logic [sibs_pkg::POS_OUT_W-1:0]      r_position;

    logic                w_accept;
    logic                w_load;
    logic                w_done;
    sibs_pkg::t_cell_ctl w_ctl;
    sibs_pkg::t_link     w_link [sibs_pkg::DEPTH+1];
    sibs_pkg::t_leaf     w_leaf [sibs_pkg::DEPTH];
    sibs_pkg::t_leaf     w_root;

    assign i_in.ready     = !r_busy;
    assign w_accept       = i_in.valid && !r_busy;
    assign w_load         = w_accept && (i_in.command == sibs_pkg::CMD_LOAD)
                            && (r_count != sibs_pkg::COUNT_FULL);
    assign w_done         = r_busy && (r_wait == sibs_pkg::WAIT_DONE)
                            && (!r_out_valid || o_out.ready);

    assign o_out.valid    = r_out_valid;
    assign o_out.found    = r_found;
    assign o_out.position = r_position;

    always_comb begin
        w_ctl.clear   = w_accept && (i_in.command == sibs_pkg::CMD_CLEAR);
        w_ctl.load    = w_load;
        w_ctl.key     = r_busy ? r_key : i_in.value;
        w_ctl.new_pos = r_count[sibs_pkg::PW-1:0];
    end

    // Left of the first cell stands a virtual entry below every key.
    assign w_link[0] = '{valid: 1'b1, value: '0, pos: '0, gt: 1'b0, eq: 1'b0};

    for (genvar i = 0; i < sibs_pkg::DEPTH; i++) begin : g_cell
        sibs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_link[i]),
            .o_link  (w_link[i+1]),
            .o_leaf  (w_leaf[i])
        );
    end

    sibs_or_tree u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_wait      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && (i_in.command == sibs_pkg::CMD_CLEAR)) begin
                r_count <= '0;
            end else if (w_load) begin
                r_count <= r_count + 1'b1;
            end

            if (w_accept && (i_in.command == sibs_pkg::CMD_QUERY)) begin
                r_busy <= 1'b1;
                r_wait <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (r_busy && (r_wait != sibs_pkg::WAIT_DONE)) begin
                r_wait <= r_wait + 1'b1;
            end

            // hold the result until taken; a finished query reloads it
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_in.value;
        end
        if (w_done) begin
            r_found    <= w_root.hit;
            r_position <= w_root.hit ? sibs_pkg::to_position(w_root.pos)
                                     : sibs_pkg::POS_NONE;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sibs_pkg::COUNT_FULL)
        else $error("entry count beyond table depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.command == sibs_pkg::CMD_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty the table");

    a_load_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_count == $past(r_count) + 1'b1))
        else $error("load did not advance the entry count");

    a_miss_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_position == sibs_pkg::POS_NONE))
        else $error("miss result without the not-found position");

endmodule
